FILE: design/lrufr_pkg.sv
`default_nettype none

package lrufr_pkg;

    // Frame count, the age width that follows from it, and the frame field width.
    localparam int FRAMES  = 64;
    localparam int AGE_W   = $clog2(FRAMES);
    localparam int FIELD_W = 6;

    typedef logic [FIELD_W-1:0] frame_field_t;
    typedef logic [AGE_W-1:0]   age_t;

    // Recency update handed to the age array.
    typedef struct packed {
        logic         en;
        frame_field_t frame;
    } lrufr_upd_t;

endpackage : lrufr_pkg

`default_nettype wire

FILE: design/lrufr_if.sv
`default_nettype none

interface lrufr_access_if;
    import lrufr_pkg::*;

    logic         valid;
    logic         ready;
    frame_field_t ref_frame;

    modport source (output valid, output ref_frame, input ready);
    modport sink   (input valid, input ref_frame, output ready);
endinterface : lrufr_access_if

interface lrufr_victim_if;
    import lrufr_pkg::*;

    logic         valid;
    logic         ready;
    frame_field_t victim_frame;

    modport source (output valid, output victim_frame, input ready);
    modport sink   (input valid, input victim_frame, output ready);
endinterface : lrufr_victim_if

`default_nettype wire

FILE: design/lrufr_age_array.sv
`default_nettype none

module lrufr_age_array (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lrufr_pkg::lrufr_upd_t upd,
    output      lrufr_pkg::frame_field_t victim_next
);
    import lrufr_pkg::*;

    // One age lane per frame: 0 is most recent, FRAMES-1 is the victim.
    age_t              age_reg  [FRAMES];
    age_t              age_next [FRAMES];
    logic [FRAMES-1:0] hit;
    age_t              age_sel;
    age_t              enc;

    always_comb
    begin
        age_sel = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            hit[i]  = upd.en && (32'(upd.frame) == i);
            age_sel = age_sel | (hit[i] ? age_reg[i] : '0);
        end
    end

    // Zero the referenced lane, age every lane that was more recent.
    always_comb
    begin
        enc = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (hit[i])
            begin
                age_next[i] = '0;
            end
            else if (upd.en && (age_reg[i] < age_sel))
            begin
                age_next[i] = age_reg[i] + age_t'(1);
            end
            else
            begin
                age_next[i] = age_reg[i];
            end
            if (age_next[i] == age_t'(FRAMES - 1))
            begin
                enc = enc | age_t'(i);
            end
        end
    end

    assign victim_next = frame_field_t'(enc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                age_reg[i] <= age_t'(i);
            end
        end
        else
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

endmodule : lrufr_age_array

`default_nettype wire

FILE: design/lru_frame_replacement.sv
// An accepted request moves into the request register, then its victim into the result register on the output.
// Throughput: one request per cycle while victim.ready does not stall the result register.
// Reset (rst_n, async, active low): recency order frame 0 most recent
// through frame FRAMES-1 least recent; both pipeline slots empty.
`default_nettype none

module lru_frame_replacement (
    input wire logic       clk,
    input wire logic       rst_n,
    lrufr_access_if.sink   access,
    lrufr_victim_if.source victim
);
    import lrufr_pkg::*;

    // Exact LRU kept as one age per frame. A reference zeroes its frame's
    // age and increments every age below it, which is the same order a
    // move-to-front linked list keeps. The victim is the frame of
    // maximum age. A reference to the head changes nothing, and a frame
    // number at or past FRAMES is dropped without touching the order.

    // Input request register.
    logic         req_vld_reg;
    frame_field_t req_frame_reg;

    // Result register.
    logic         rsp_vld_reg;
    frame_field_t rsp_frame_reg;

    logic         advance;
    logic         in_range;
    lrufr_upd_t   upd;
    frame_field_t victim_next;

    // Advance when the result slot is free or being drained.
    assign advance      = !rsp_vld_reg || victim.ready;
    assign access.ready = !req_vld_reg || advance;

    assign in_range  = (32'(req_frame_reg) < FRAMES);
    assign upd.en    = req_vld_reg && advance && in_range;
    assign upd.frame = req_frame_reg;

    lrufr_age_array u_age_array (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .victim_next (victim_next)
    );

    // Hold the request until it can move into the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            req_vld_reg <= access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.ready && access.valid)
        begin
            req_frame_reg <= access.ref_frame;
        end
    end

    // Load the victim after the update; drop the slot once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_vld_reg <= req_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req_vld_reg)
        begin
            rsp_frame_reg <= victim_next;
        end
    end

    assign victim.valid        = rsp_vld_reg;
    assign victim.victim_frame = rsp_frame_reg;

`ifndef NO_ASSERTIONS
    // A request that advances always lands in the result slot.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && advance) |=> rsp_vld_reg)
        else $error("request advanced but result slot stayed empty");

    // A result appears only from a held request.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_vld_reg) |-> $past(req_vld_reg))
        else $error("result appeared without a request");

    // The frame just referenced is most recent, so it is never the victim.
    a_victim_not_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && advance && in_range) |=> (rsp_frame_reg != $past(req_frame_reg)))
        else $error("victim equals the frame just referenced");
`endif

endmodule : lru_frame_replacement

`default_nettype wire

FILE: tb/sv/lrufr_victim_check.sv
`default_nettype none

// Watches both channels, keeps its own recency list and compares each victim
// against the one predicted for the oldest outstanding request.
module lrufr_victim_check (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    access_valid,
    input  wire logic                    access_ready,
    input  wire lrufr_pkg::frame_field_t ref_frame,
    input  wire logic                    victim_valid,
    input  wire logic                    victim_ready,
    input  wire lrufr_pkg::frame_field_t victim_frame,
    output int                           error_count,
    output int                           pending_count
);
    import lrufr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] NO_LINK = 7'(FRAMES);

    logic [6:0]   toward_mru [FRAMES];
    logic [6:0]   toward_lru [FRAMES];
    frame_field_t mru_frame;
    frame_field_t lru_frame;
    frame_field_t victims_due [$];

    task automatic clear_order();
        for (int i = 0; i < FRAMES; i++)
        begin
            toward_mru[i] = (i == 0) ? NO_LINK : 7'(i - 1);
            toward_lru[i] = (i == FRAMES - 1) ? NO_LINK : 7'(i + 1);
        end
        mru_frame = '0;
        lru_frame = frame_field_t'(FRAMES - 1);
    endtask

    // Move the frame to the most recent end and return the resulting victim.
    function automatic frame_field_t touch_frame(input frame_field_t f);
        logic [6:0] p;
        logic [6:0] n;
        if (int'(f) < FRAMES)
        begin
            p = toward_mru[f];
            n = toward_lru[f];
            if (f != mru_frame && p < NO_LINK)
            begin
                toward_lru[p[5:0]] = n;
                if (n < NO_LINK)
                    toward_mru[n[5:0]] = p;
                else
                    lru_frame = p[5:0];
                toward_mru[f]         = NO_LINK;
                toward_lru[f]         = {1'b0, mru_frame};
                toward_mru[mru_frame] = {1'b0, f};
                mru_frame             = f;
            end
        end
        return lru_frame;
    endfunction

    initial
    begin
        clear_order();
        error_count   = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        frame_field_t due;
        if (!rst_n)
        begin
            clear_order();
            victims_due.delete();
            pending_count <= 0;
        end
        else
        begin
            if (victim_valid && victim_ready)
            begin
                if (victims_due.size() == 0)
                begin
                    $display("%0t: victim %0d with no request outstanding", $time,
                             victim_frame);
                    error_count <= error_count + 1;
                end
                else
                begin
                    due = victims_due.pop_front();
                    if (victim_frame !== due)
                    begin
                        $display("%0t: victim_frame expected %0d, actual %0d", $time,
                                 due, victim_frame);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (access_valid && access_ready)
                victims_due.push_back(touch_frame(ref_frame));
            pending_count <= victims_due.size();
        end
    end
endmodule : lrufr_victim_check

`default_nettype wire

FILE: tb/sv/lru_frame_replacement_tb.sv
`default_nettype none

module lru_frame_replacement_tb;
    import lrufr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Far above the slowest correct run: every request waiting out a full gap
    // and a full output stall, plus the long hold-off.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_COUNT = 1300;
    localparam int HOLD_CYCLES  = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_go;
    int   error_count;
    int   pending_count;
    int   cycle_count = 0;

    lrufr_access_if access_ch ();
    lrufr_victim_if victim_ch ();

    lru_frame_replacement uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch),
        .victim (victim_ch)
    );

    lrufr_victim_check victim_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .access_valid  (access_ch.valid),
        .access_ready  (access_ch.ready),
        .ref_frame     (access_ch.ref_frame),
        .victim_valid  (victim_ch.valid),
        .victim_ready  (victim_ch.ready),
        .victim_frame  (victim_ch.victim_frame),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always #1 clk = ~clk;

    // Guard against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one request and hold it until the block takes it. Valid stays high
    // into the next call, so back-to-back requests never drop valid.
    task automatic send_request(input frame_field_t f);
        @(negedge clk);
        access_ch.valid     <= 1'b1;
        access_ch.ref_frame <= f;
        do
            @(posedge clk);
        while (access_ch.ready !== 1'b1);
    endtask

    // Drop valid and scramble the frame bus, which must be ignored; n sets the length of the idle stretch.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            access_ch.valid     <= 1'b0;
            access_ch.ref_frame <= frame_field_t'($urandom_range(0, FRAMES - 1));
        end
    endtask

    // Hold the input quiet until every predicted victim has come back.
    task automatic wait_drained();
        do
            idle_cycles(1);
        while (pending_count != 0);
    endtask

    // Receiver: cycle through several stall patterns, and once, on request,
    // hold off for a long stretch so the pipeline fills and back-pressures.
    initial
    begin : receiver
        int  cyc;
        int  hold_left;
        int  stall_left;
        bit  held;
        victim_ch.ready = 1'b0;
        cyc        = 0;
        hold_left  = 0;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                victim_ch.ready <= 1'b0;
            end
            else
            begin
                case ((cyc / 64) % 4)
                    0: victim_ch.ready <= 1'b1;
                    1: victim_ch.ready <= 1'($urandom_range(0, 1));
                    2: victim_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            victim_ch.ready <= 1'b0;
                        end
                        else if ($urandom_range(0, 5) == 0)
                        begin
                            stall_left = $urandom_range(1, 8);
                            victim_ch.ready <= 1'b0;
                        end
                        else
                            victim_ch.ready <= 1'b1;
                    end
                endcase
            end
        end
    end

    initial
    begin : stimulus
        // Extremes, head references, tail references, alternating bit patterns.
        frame_field_t directed [18] = '{
            6'd0, 6'd63, 6'd63, 6'd62, 6'd1, 6'd0, 6'd0, 6'd61,
            6'd42, 6'd21, 6'd32, 6'd31, 6'd5, 6'd5, 6'd60, 6'd59, 6'd63, 6'd0
        };
        frame_field_t f;
        frame_field_t last_frame;
        frame_field_t sweep_ptr;
        frame_field_t set_base;
        int           mode;
        int           segment_left;
        int           burst_left;

        rst_n               = 1'b0;
        hold_go             = 1'b0;
        access_ch.valid     = 1'b0;
        access_ch.ref_frame = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        foreach (directed[i])
            send_request(directed[i]);
        last_frame = directed[17];
        wait_drained();

        sweep_ptr    = frame_field_t'(FRAMES - 1);
        set_base     = '0;
        mode         = 0;
        segment_left = 0;
        burst_left   = 0;

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            // Close the burst with a gap, sometimes none at all.
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            if (n == 300)
                hold_go = 1'b1;
            if (n == 800)
                wait_drained();

            // Access pattern is picked per segment: full sweeps keep hitting the
            // tail, a small working set keeps hitting the head and its neighbors.
            if (segment_left == 0)
            begin
                mode         = $urandom_range(0, 9);
                segment_left = $urandom_range(8, 40);
                set_base     = frame_field_t'($urandom_range(0, FRAMES - 1));
            end
            segment_left--;

            if ($urandom_range(0, 9) == 0)
                f = last_frame;
            else if (mode <= 2)
            begin
                f         = sweep_ptr;
                sweep_ptr = sweep_ptr - 1'b1;
            end
            else if (mode <= 5)
                f = set_base + frame_field_t'($urandom_range(0, 3));
            else
                f = frame_field_t'($urandom_range(0, FRAMES - 1));

            send_request(f);
            last_frame = f;
        end

        wait_drained();
        idle_cycles(8);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule : lru_frame_replacement_tb

`default_nettype wire

FILE: filelist.f
design/lrufr_pkg.sv
design/lrufr_if.sv
design/lrufr_age_array.sv
design/lru_frame_replacement.sv
tb/sv/lrufr_victim_check.sv
tb/sv/lru_frame_replacement_tb.sv
